// ===== rtl/resource_health_level_monitor_unit_macros.svh =====
// Assertion macros used by the checker file of the health monitor.
`ifndef RESOURCE_HEALTH_LEVEL_MONITOR_UNIT_MACROS_SVH
`define RESOURCE_HEALTH_LEVEL_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RHLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("health monitor check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RHLM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("health monitor check failed");

`endif

// ===== rtl/rhlm_pkg.sv =====
// Types, constants and level functions of the health monitor.
`timescale 1ns / 1ps
package rhlm_pkg;

	localparam int MAX_PROBES = 4;
	localparam int HR_W       = 20;
	localparam int HEAP_W     = 24;
	localparam int CNT_W      = 8;
	localparam int RATIO_W    = 10;
	localparam int MASK_W     = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;
	localparam int PROD_W     = HEAP_W + RATIO_W;
	localparam int DIV_STEPS  = RATIO_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	typedef logic [1:0] lvl_t;
	localparam lvl_t LVL_OK   = 2'd0;
	localparam lvl_t LVL_WARN = 2'd1;
	localparam lvl_t LVL_CRIT = 2'd2;

	localparam logic [HEAP_W-1:0]  HEAP_LARGEST_WARN  = 24'd49152;
	localparam logic [HEAP_W-1:0]  HEAP_LARGEST_CRIT  = 24'd32768;
	localparam logic [HEAP_W-1:0]  HEAP_LARGEST_CLEAR = 24'd65536;
	localparam logic [RATIO_W-1:0] HEAP_RATIO_WARN    = 10'd350;
	localparam logic [RATIO_W-1:0] HEAP_RATIO_CRIT    = 10'd250;
	localparam logic [RATIO_W-1:0] HEAP_RATIO_CLEAR   = 10'd450;
	localparam logic [RATIO_W-1:0] RATIO_FULL         = 10'd1000;
	localparam logic [CNT_W-1:0]   COUNT_MAX          = 8'd255;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STACK_WARN_ENTER = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_WARN_CLEAR = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_CRIT_ENTER = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_CRIT_CLEAR = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_FREE_WARN   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_FREE_CRIT   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_FREE_CLEAR  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_SAMPLES  = 4'd7;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic commit;
	} rhlm_cmd_t;

	typedef struct packed {
		logic out_free;
	} rhlm_stat_t;

	typedef struct packed {
		lvl_t             cur;
		lvl_t             pend;
		logic [CNT_W-1:0] cnt;
		logic             changed;
	} gate_res_t;

	function automatic lvl_t stack_target(input lvl_t cur, input logic [HR_W-1:0] h,
			input logic [HR_W-1:0] warn_on, input logic [HR_W-1:0] warn_off,
			input logic [HR_W-1:0] crit_on, input logic [HR_W-1:0] crit_off);
		lvl_t t;
		if (cur == LVL_CRIT) begin
			if (h < crit_off) t = LVL_CRIT;
			else if (h <= warn_on) t = LVL_WARN;
			else t = LVL_OK;
		end else if (cur == LVL_WARN) begin
			if (h <= crit_on) t = LVL_CRIT;
			else if (h >= warn_off) t = LVL_OK;
			else t = LVL_WARN;
		end else begin
			if (h <= crit_on) t = LVL_CRIT;
			else if (h <= warn_on) t = LVL_WARN;
			else t = LVL_OK;
		end
		return t;
	endfunction

	function automatic lvl_t heap_target(input lvl_t cur, input logic [HEAP_W-1:0] fr,
			input logic [HEAP_W-1:0] lg, input logic [RATIO_W-1:0] ratio,
			input logic [HEAP_W-1:0] fr_warn, input logic [HEAP_W-1:0] fr_crit,
			input logic [HEAP_W-1:0] fr_ok);
		lvl_t raw;
		lvl_t t;
		logic below_clear;
		if (fr <= fr_crit || lg <= HEAP_LARGEST_CRIT || ratio <= HEAP_RATIO_CRIT)
			raw = LVL_CRIT;
		else if (fr <= fr_warn || lg <= HEAP_LARGEST_WARN || ratio <= HEAP_RATIO_WARN)
			raw = LVL_WARN;
		else
			raw = LVL_OK;
		below_clear = (fr < fr_ok) || (lg < HEAP_LARGEST_CLEAR) ||
			(ratio < HEAP_RATIO_CLEAR);
		if (raw == LVL_CRIT) t = LVL_CRIT;
		else if (cur == LVL_CRIT) t = below_clear ? LVL_CRIT : raw;
		else if (cur == LVL_WARN) t = (raw == LVL_WARN || below_clear) ? LVL_WARN : LVL_OK;
		else t = raw;
		return t;
	endfunction

	// Debounce: adopt a differing target only after a run of agreeing samples
	function automatic gate_res_t level_gate(input lvl_t cur, input lvl_t target,
			input lvl_t pend, input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] confirm);
		gate_res_t r;
		logic [CNT_W-1:0] n;
		r.cur     = cur;
		r.pend    = target;
		r.cnt     = '0;
		r.changed = 1'b0;
		if (cur != target) begin
			if (pend != target) n = 8'd1;
			else if (cnt < COUNT_MAX) n = cnt + 8'd1;
			else n = cnt;
			if (n >= confirm) begin
				r.cur     = target;
				r.changed = 1'b1;
			end else begin
				r.cnt = n;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/rhlm_tick_if.sv =====
// Handshake channel carrying one tick item of probe and heap samples.
`timescale 1ns / 1ps
interface rhlm_tick_if;
	logic        valid;
	logic        ready;
	logic        probe_valid_0;
	logic [19:0] probe_headroom_0;
	logic        probe_valid_1;
	logic [19:0] probe_headroom_1;
	logic        probe_valid_2;
	logic [19:0] probe_headroom_2;
	logic        probe_valid_3;
	logic [19:0] probe_headroom_3;
	logic [23:0] heap_free_bytes;
	logic [23:0] heap_largest_block;

	modport source (
		output valid, probe_valid_0, probe_headroom_0, probe_valid_1, probe_headroom_1,
			probe_valid_2, probe_headroom_2, probe_valid_3, probe_headroom_3,
			heap_free_bytes, heap_largest_block,
		input ready
	);
	modport sink (
		input valid, probe_valid_0, probe_headroom_0, probe_valid_1, probe_headroom_1,
			probe_valid_2, probe_headroom_2, probe_valid_3, probe_headroom_3,
			heap_free_bytes, heap_largest_block,
		output ready
	);
endinterface

// ===== rtl/rhlm_status_if.sv =====
// Handshake channel carrying one status item of levels, ratio and transitions.
`timescale 1ns / 1ps
interface rhlm_status_if;
	logic       valid;
	logic       ready;
	logic [1:0] probe_level_0;
	logic [1:0] probe_level_1;
	logic [1:0] probe_level_2;
	logic [1:0] probe_level_3;
	logic [1:0] heap_lvl;
	logic [9:0] heap_ratio_permille;
	logic [4:0] transition_mask;

	modport source (
		output valid, probe_level_0, probe_level_1, probe_level_2, probe_level_3,
			heap_lvl, heap_ratio_permille, transition_mask,
		input ready
	);
	modport sink (
		input valid, probe_level_0, probe_level_1, probe_level_2, probe_level_3,
			heap_lvl, heap_ratio_permille, transition_mask,
		output ready
	);
endinterface

// ===== rtl/rhlm_ctrl.sv =====
// Controller: sequences capture, multiply, serial divide and commit of a tick.
`timescale 1ns / 1ps
module rhlm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output rhlm_pkg::rhlm_cmd_t    cmd,
	input  rhlm_pkg::rhlm_stat_t   stat
);
	import rhlm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EVAL
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_EVAL) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= ST_EVAL;
					else step_q <= step_q + 1'b1;
				end
				ST_EVAL: begin
					// hold until the output register can take the item
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rhlm_dp.sv =====
// Datapath: config registers, ratio divider, level state and output register.
`timescale 1ns / 1ps
module rhlm_dp #(
	parameter int NUM_PROBES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rhlm_pkg::rhlm_cmd_t                 cmd,
	output rhlm_pkg::rhlm_stat_t                stat,
	input  logic                                wr_en,
	input  logic [rhlm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [rhlm_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic [rhlm_pkg::MAX_PROBES-1:0]     probe_valid,
	input  logic [rhlm_pkg::HR_W-1:0]           probe_headroom [rhlm_pkg::MAX_PROBES],
	input  logic [rhlm_pkg::HEAP_W-1:0]         heap_free_bytes,
	input  logic [rhlm_pkg::HEAP_W-1:0]         heap_largest_block,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rhlm_pkg::lvl_t                      probe_level [rhlm_pkg::MAX_PROBES],
	output rhlm_pkg::lvl_t                      heap_lvl,
	output logic [rhlm_pkg::RATIO_W-1:0]        heap_ratio_permille,
	output logic [rhlm_pkg::MASK_W-1:0]         transition_mask
);
	import rhlm_pkg::*;

	// configuration
	logic [HR_W-1:0]   swe_q, swc_q, sce_q, scc_q;
	logic [HEAP_W-1:0] hfw_q, hfc_q, hfcl_q;
	logic [CNT_W-1:0]  confirm_q;

	// captured tick
	logic [MAX_PROBES-1:0] pv_q;
	logic [HR_W-1:0]       hr_q [MAX_PROBES];
	logic [HEAP_W-1:0]     fr_q, lg_q;

	// divider
	logic [PROD_W-1:0]  prod;
	logic [HEAP_W-1:0]  rem_q;
	logic [RATIO_W-1:0] lo_q, quo_q;
	logic               zero_q, full_q;
	logic [HEAP_W:0]    trial, dvs, diff;
	logic               ge;
	logic [RATIO_W-1:0] ratio;

	// level state and results
	gate_res_t             pg [MAX_PROBES];
	gate_res_t             hg;
	lvl_t                  hlvl_q, hpend_q;
	logic [CNT_W-1:0]      hcnt_q;
	lvl_t                  out_lvl_q [MAX_PROBES];
	lvl_t                  out_heap_q;
	logic [RATIO_W-1:0]    out_ratio_q;
	logic [MASK_W-1:0]     out_mask_q;
	logic                  out_valid_q;
	logic [MAX_PROBES-1:0] pmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swe_q     <= 20'd1024;
			swc_q     <= 20'd1536;
			sce_q     <= 20'd512;
			scc_q     <= 20'd1024;
			hfw_q     <= 24'd98304;
			hfc_q     <= 24'd65536;
			hfcl_q    <= 24'd131072;
			confirm_q <= 8'd2;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STACK_WARN_ENTER: swe_q     <= wr_data[HR_W-1:0];
				REG_STACK_WARN_CLEAR: swc_q     <= wr_data[HR_W-1:0];
				REG_STACK_CRIT_ENTER: sce_q     <= wr_data[HR_W-1:0];
				REG_STACK_CRIT_CLEAR: scc_q     <= wr_data[HR_W-1:0];
				REG_HEAP_FREE_WARN:   hfw_q     <= wr_data[HEAP_W-1:0];
				REG_HEAP_FREE_CRIT:   hfc_q     <= wr_data[HEAP_W-1:0];
				REG_HEAP_FREE_CLEAR:  hfcl_q    <= wr_data[HEAP_W-1:0];
				REG_CONFIRM_SAMPLES:  confirm_q <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pv_q <= probe_valid;
			hr_q <= probe_headroom;
			fr_q <= heap_free_bytes;
			lg_q <= heap_largest_block;
		end
	end

	// Quotient stays below 1024 whenever largest < free, so the top bits of the
	// product seed the remainder and ten restoring steps finish the division.
	assign prod  = PROD_W'(lg_q) * PROD_W'(RATIO_FULL);
	assign trial = {rem_q, lo_q[RATIO_W-1]};
	assign dvs   = {1'b0, fr_q};
	assign ge    = (trial >= dvs);
	assign diff  = trial - dvs;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q  <= prod[PROD_W-1:RATIO_W];
			lo_q   <= prod[RATIO_W-1:0];
			quo_q  <= '0;
			zero_q <= (fr_q == '0);
			full_q <= (lg_q >= fr_q);
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[HEAP_W-1:0] : trial[HEAP_W-1:0];
			lo_q  <= {lo_q[RATIO_W-2:0], 1'b0};
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
	end

	assign ratio = zero_q ? '0 : (full_q ? RATIO_FULL : quo_q);

	for (genvar i = 0; i < MAX_PROBES; i++) begin : g_probe
		if (i < NUM_PROBES) begin : g_live
			lvl_t             lvl_q, pend_q;
			logic [CNT_W-1:0] cnt_q;

			always_comb begin
				if (pv_q[i]) begin
					pg[i] = level_gate(lvl_q,
						stack_target(lvl_q, hr_q[i], swe_q, swc_q, sce_q, scc_q),
						pend_q, cnt_q, confirm_q);
				end else begin
					// no sample: hold the state untouched
					pg[i].cur     = lvl_q;
					pg[i].pend    = pend_q;
					pg[i].cnt     = cnt_q;
					pg[i].changed = 1'b0;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					lvl_q  <= LVL_OK;
					pend_q <= LVL_OK;
					cnt_q  <= '0;
				end else if (cmd.commit) begin
					lvl_q  <= pg[i].cur;
					pend_q <= pg[i].pend;
					cnt_q  <= pg[i].cnt;
				end
			end
		end else begin : g_absent
			assign pg[i] = '{cur: LVL_OK, pend: LVL_OK, cnt: '0, changed: 1'b0};
		end
		assign pmask[i] = pg[i].changed;
	end

	assign hg = level_gate(hlvl_q,
		heap_target(hlvl_q, fr_q, lg_q, ratio, hfw_q, hfc_q, hfcl_q),
		hpend_q, hcnt_q, confirm_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlvl_q      <= LVL_OK;
			hpend_q     <= LVL_OK;
			hcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				hlvl_q      <= hg.cur;
				hpend_q     <= hg.pend;
				hcnt_q      <= hg.cnt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < MAX_PROBES; i++) out_lvl_q[i] <= pg[i].cur;
			out_heap_q  <= hg.cur;
			out_ratio_q <= ratio;
			out_mask_q  <= {hg.changed, pmask};
		end
	end

	assign stat.out_free       = !out_valid_q || out_ready;
	assign out_valid           = out_valid_q;
	assign probe_level         = out_lvl_q;
	assign heap_lvl            = out_heap_q;
	assign heap_ratio_permille = out_ratio_q;
	assign transition_mask     = out_mask_q;

endmodule

// ===== rtl/resource_health_level_monitor_unit.sv =====
// A tick item is accepted only while idle and then passes through capture,
// multiply, the 10-step serial ratio divider and commit before the next item
// is accepted; a full output register stalls commit.
// The output register lets the next item be accepted while a result waits.
// Reset (arst_n low): levels OK, pending counts zero, thresholds at defaults,
// no result pending.
`timescale 1ns / 1ps
module resource_health_level_monitor_unit #(
	parameter int NUM_PROBES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rhlm_tick_if.sink                       tick,
	rhlm_status_if.source                   status,
	input  logic                            wr_en,
	input  logic [rhlm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rhlm_pkg::CFG_DATA_W-1:0] wr_data
);
	import rhlm_pkg::*;

	rhlm_cmd_t             cmd;
	rhlm_stat_t            stat;
	logic [MAX_PROBES-1:0] probe_valid;
	logic [HR_W-1:0]       probe_headroom [MAX_PROBES];
	lvl_t                  probe_level [MAX_PROBES];

	assign probe_valid       = {tick.probe_valid_3, tick.probe_valid_2,
		tick.probe_valid_1, tick.probe_valid_0};
	assign probe_headroom[0] = tick.probe_headroom_0;
	assign probe_headroom[1] = tick.probe_headroom_1;
	assign probe_headroom[2] = tick.probe_headroom_2;
	assign probe_headroom[3] = tick.probe_headroom_3;

	rhlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	rhlm_dp #(
		.NUM_PROBES (NUM_PROBES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.wr_en               (wr_en),
		.wr_index            (wr_index),
		.wr_data             (wr_data),
		.probe_valid         (probe_valid),
		.probe_headroom      (probe_headroom),
		.heap_free_bytes     (tick.heap_free_bytes),
		.heap_largest_block  (tick.heap_largest_block),
		.out_valid           (status.valid),
		.out_ready           (status.ready),
		.probe_level         (probe_level),
		.heap_lvl            (status.heap_lvl),
		.heap_ratio_permille (status.heap_ratio_permille),
		.transition_mask     (status.transition_mask)
	);

	assign status.probe_level_0 = probe_level[0];
	assign status.probe_level_1 = probe_level[1];
	assign status.probe_level_2 = probe_level[2];
	assign status.probe_level_3 = probe_level[3];

endmodule

// ===== rtl/rhlm_checker.sv =====
// Port-level checks of the health monitor and their bind to the top level.
`timescale 1ns / 1ps
`include "resource_health_level_monitor_unit_macros.svh"
module rhlm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] lvl_0,
	input logic [1:0] lvl_1,
	input logic [1:0] lvl_2,
	input logic [1:0] lvl_3,
	input logic [1:0] lvl_heap,
	input logic [9:0] ratio,
	input logic [4:0] mask
);

	logic levels_legal;

	assign levels_legal = (ratio <= 10'd1000) && (lvl_0 != 2'd3) && (lvl_1 != 2'd3) &&
		(lvl_2 != 2'd3) && (lvl_3 != 2'd3) && (lvl_heap != 2'd3);

	// one item in flight: no new item right after an accepted one
	`RHLM_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready)
	// a result appears only out of the busy phase
	`RHLM_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(!in_ready))
	`RHLM_ASSERT_IMP(a_levels_legal, out_valid, levels_legal)
	`RHLM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(mask) && $stable(ratio))

endmodule

bind resource_health_level_monitor_unit rhlm_checker u_rhlm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tick.valid),
	.in_ready  (tick.ready),
	.out_valid (status.valid),
	.out_ready (status.ready),
	.lvl_0     (status.probe_level_0),
	.lvl_1     (status.probe_level_1),
	.lvl_2     (status.probe_level_2),
	.lvl_3     (status.probe_level_3),
	.lvl_heap  (status.heap_lvl),
	.ratio     (status.heap_ratio_permille),
	.mask      (status.transition_mask)
);

// ===== tb/resource_health_level_monitor_unit_tb.sv =====
// Self-checking testbench: random tick items against a level predictor, random handshake gaps.
`timescale 1ns / 1ps
module resource_health_level_monitor_unit_tb;
	import rhlm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd11;

	typedef struct packed {
		logic [3:0]             pv;
		logic [3:0][HR_W-1:0]   hr;
		logic [HEAP_W-1:0]      fr;
		logic [HEAP_W-1:0]      lg;
	} tick_item_t;

	typedef struct packed {
		lvl_t [3:0]             lvl;
		lvl_t                   heap;
		logic [RATIO_W-1:0]     ratio;
		logic [MASK_W-1:0]      mask;
	} health_status_t;

	typedef struct packed {
		logic [HR_W-1:0]   warn_on;
		logic [HR_W-1:0]   warn_off;
		logic [HR_W-1:0]   crit_on;
		logic [HR_W-1:0]   crit_off;
		logic [HEAP_W-1:0] fr_warn;
		logic [HEAP_W-1:0] fr_crit;
		logic [HEAP_W-1:0] fr_ok;
		logic [CNT_W-1:0]  confirm;
	} thresholds_t;

	localparam thresholds_t RESET_LIMITS = '{
		warn_on: 20'd1024, warn_off: 20'd1536, crit_on: 20'd512, crit_off: 20'd1024,
		fr_warn: 24'd98304, fr_crit: 24'd65536, fr_ok: 24'd131072, confirm: 8'd2
	};

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	rhlm_tick_if tick_ch ();
	rhlm_status_if status_ch ();

	resource_health_level_monitor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.status   (status_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Predictor copy of the thresholds and the debounce state; channel 4 is the heap
	thresholds_t thr;
	lvl_t chan_lvl [5];
	lvl_t chan_pend [5];
	logic [CNT_W-1:0] chan_cnt [5];

	health_status_t due_status [$];
	int mismatches;
	int items_sent;
	int results_seen;
	int level_changes;
	int settings_used;
	int stall_left;
	bit steady_flow;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("Timeout with %0d results still outstanding", due_status.size());
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic lvl_t probe_goal(input lvl_t cur, input logic [HR_W-1:0] h);
		lvl_t goal;
		case (cur)
			LVL_CRIT: goal = (h < thr.crit_off) ? LVL_CRIT :
				(h <= thr.warn_on) ? LVL_WARN : LVL_OK;
			LVL_WARN: goal = (h <= thr.crit_on) ? LVL_CRIT :
				(h >= thr.warn_off) ? LVL_OK : LVL_WARN;
			default: goal = (h <= thr.crit_on) ? LVL_CRIT :
				(h <= thr.warn_on) ? LVL_WARN : LVL_OK;
		endcase
		return goal;
	endfunction

	function automatic lvl_t heap_goal(input lvl_t cur, input logic [HEAP_W-1:0] fr,
			input logic [HEAP_W-1:0] lg, input logic [RATIO_W-1:0] ratio);
		lvl_t raw;
		logic short_of_clear;
		if (fr <= thr.fr_crit || lg <= HEAP_LARGEST_CRIT || ratio <= HEAP_RATIO_CRIT)
			raw = LVL_CRIT;
		else if (fr <= thr.fr_warn || lg <= HEAP_LARGEST_WARN || ratio <= HEAP_RATIO_WARN)
			raw = LVL_WARN;
		else
			raw = LVL_OK;
		short_of_clear = fr < thr.fr_ok || lg < HEAP_LARGEST_CLEAR ||
			ratio < HEAP_RATIO_CLEAR;
		if (raw == LVL_CRIT)
			return LVL_CRIT;
		if (cur == LVL_CRIT)
			return short_of_clear ? LVL_CRIT : raw;
		if (cur == LVL_WARN)
			return (raw == LVL_WARN || short_of_clear) ? LVL_WARN : LVL_OK;
		return raw;
	endfunction

	// Count agreeing samples; adopt the goal once the run is long enough
	function automatic bit settle(input int ch, input lvl_t goal);
		if (chan_lvl[ch] == goal) begin
			chan_pend[ch] = goal;
			chan_cnt[ch] = '0;
			return 1'b0;
		end
		if (chan_pend[ch] != goal) begin
			chan_pend[ch] = goal;
			chan_cnt[ch] = 8'd1;
		end else if (chan_cnt[ch] != COUNT_MAX) begin
			chan_cnt[ch] = chan_cnt[ch] + 8'd1;
		end
		if (chan_cnt[ch] >= thr.confirm) begin
			chan_lvl[ch] = goal;
			chan_cnt[ch] = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic health_status_t forecast_status(input tick_item_t t);
		health_status_t s;
		logic [63:0] quot;
		s.mask = '0;
		for (int i = 0; i < 4; i++) begin
			if (t.pv[i]) begin
				if (settle(i, probe_goal(chan_lvl[i], t.hr[i])))
					s.mask[i] = 1'b1;
			end
			s.lvl[i] = chan_lvl[i];
		end
		if (t.fr == '0) begin
			s.ratio = '0;
		end else begin
			quot = (64'(t.lg) * 64'(RATIO_FULL)) / 64'(t.fr);
			s.ratio = (quot > 64'(RATIO_FULL)) ? RATIO_FULL : quot[RATIO_W-1:0];
		end
		if (settle(4, heap_goal(chan_lvl[4], t.fr, t.lg, s.ratio)))
			s.mask[4] = 1'b1;
		s.heap = chan_lvl[4];
		return s;
	endfunction

	// ---------------------------------------------------------------- random values

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [HEAP_W-1:0] near(input logic [HEAP_W-1:0] base,
			input logic [HEAP_W-1:0] top);
		int v;
		v = int'(base) + int'($urandom_range(0, 6)) - 3;
		if (v < 0) v = 0;
		if (v > int'(top)) v = int'(top);
		return v[HEAP_W-1:0];
	endfunction

	function automatic logic [HR_W-1:0] random_headroom();
		logic [HEAP_W-1:0] top;
		top = 24'hFFFFF;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return HR_W'($urandom);
			4: return HR_W'(near(24'(thr.warn_on), top));
			5: return HR_W'(near(24'(thr.warn_off), top));
			6: return HR_W'(near(24'(thr.crit_on), top));
			7: return HR_W'(near(24'(thr.crit_off), top));
			default: return HR_W'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic logic [HEAP_W-1:0] random_free();
		case ($urandom_range(0, 8))
			0: return '0;
			1: return '1;
			2, 3: return HEAP_W'($urandom);
			4: return near(thr.fr_warn, '1);
			5: return near(thr.fr_crit, '1);
			6: return near(thr.fr_ok, '1);
			default: return HEAP_W'($urandom_range(1, 300000));
		endcase
	endfunction

	function automatic logic [HEAP_W-1:0] random_largest(input logic [HEAP_W-1:0] fr);
		logic [63:0] scaled;
		logic [RATIO_W-1:0] pm;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return HEAP_W'($urandom);
			3: return near(HEAP_LARGEST_CRIT, '1);
			4: return near(HEAP_LARGEST_WARN, '1);
			5: return near(HEAP_LARGEST_CLEAR, '1);
			6, 7: begin
				// land on or beside a ratio threshold
				case ($urandom_range(0, 2))
					0: pm = HEAP_RATIO_CRIT;
					1: pm = HEAP_RATIO_WARN;
					default: pm = HEAP_RATIO_CLEAR;
				endcase
				scaled = (64'(fr) * 64'(pm) + 64'd999) / 64'd1000;
				scaled = scaled + $urandom_range(0, 2) - 1;
				return scaled[HEAP_W-1:0];
			end
			8: return near(fr, '1) + HEAP_W'($urandom_range(0, 1000));
			default: return HEAP_W'($urandom_range(0, 200000));
		endcase
	endfunction

	function automatic tick_item_t random_tick();
		tick_item_t t;
		for (int i = 0; i < 4; i++) begin
			t.pv[i] = ($urandom_range(0, 7) != 0);
			t.hr[i] = random_headroom();
		end
		t.fr = random_free();
		t.lg = random_largest(t.fr);
		return t;
	endfunction

	function automatic tick_item_t mk_tick(input logic [3:0] pv, input logic [HR_W-1:0] h0,
			input logic [HR_W-1:0] h1, input logic [HR_W-1:0] h2, input logic [HR_W-1:0] h3,
			input logic [HEAP_W-1:0] fr, input logic [HEAP_W-1:0] lg);
		tick_item_t t;
		t.pv = pv;
		t.hr = {h3, h2, h1, h0};
		t.fr = fr;
		t.lg = lg;
		return t;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic send_tick(input tick_item_t t);
		int gap;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.probe_valid_0 <= t.pv[0];
		tick_ch.probe_valid_1 <= t.pv[1];
		tick_ch.probe_valid_2 <= t.pv[2];
		tick_ch.probe_valid_3 <= t.pv[3];
		tick_ch.probe_headroom_0 <= t.hr[0];
		tick_ch.probe_headroom_1 <= t.hr[1];
		tick_ch.probe_headroom_2 <= t.hr[2];
		tick_ch.probe_headroom_3 <= t.hr[3];
		tick_ch.heap_free_bytes <= t.fr;
		tick_ch.heap_largest_block <= t.lg;
		@(posedge clk);
		while (tick_ch.ready !== 1'b1) @(posedge clk);
		due_status.push_back(forecast_status(t));
		items_sent++;
	endtask

	// Hold the sender until every outstanding result is back
	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (due_status.size() != 0) @(posedge clk);
	endtask

	// Leaves wr_en high; the caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_STACK_WARN_ENTER: thr.warn_on = data[HR_W-1:0];
			REG_STACK_WARN_CLEAR: thr.warn_off = data[HR_W-1:0];
			REG_STACK_CRIT_ENTER: thr.crit_on = data[HR_W-1:0];
			REG_STACK_CRIT_CLEAR: thr.crit_off = data[HR_W-1:0];
			REG_HEAP_FREE_WARN:   thr.fr_warn = data;
			REG_HEAP_FREE_CRIT:   thr.fr_crit = data;
			REG_HEAP_FREE_CLEAR:  thr.fr_ok = data;
			REG_CONFIRM_SAMPLES:  thr.confirm = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_limits(input thresholds_t c);
		write_reg(REG_STACK_WARN_ENTER, 24'(c.warn_on));
		write_reg(REG_STACK_WARN_CLEAR, 24'(c.warn_off));
		write_reg(REG_STACK_CRIT_ENTER, 24'(c.crit_on));
		write_reg(REG_STACK_CRIT_CLEAR, 24'(c.crit_off));
		write_reg(REG_HEAP_FREE_WARN, c.fr_warn);
		write_reg(REG_HEAP_FREE_CRIT, c.fr_crit);
		write_reg(REG_HEAP_FREE_CLEAR, c.fr_ok);
		write_reg(REG_CONFIRM_SAMPLES, 24'(c.confirm));
		wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Runs of repeated samples, at most twice the confirm count plus two and never over 12, with dropped probes and noise
	task automatic run_ticks(input int count);
		int left;
		int run;
		int max_run;
		tick_item_t base;
		tick_item_t item;
		left = count;
		while (left > 0) begin
			steady_flow = ($urandom_range(0, 7) == 0);
			max_run = int'(thr.confirm) * 2 + 2;
			if (max_run > 12) max_run = 12;
			run = $urandom_range(1, max_run);
			if (run > left) run = left;
			base = random_tick();
			for (int k = 0; k < run; k++) begin
				item = base;
				if ($urandom_range(0, 9) == 0) begin
					item = random_tick();
				end else begin
					for (int i = 0; i < 4; i++)
						if ($urandom_range(0, 7) == 0) item.pv[i] = 1'b0;
				end
				send_tick(item);
			end
			left -= run;
		end
		steady_flow = 1'b0;
	endtask

	// ---------------------------------------------------------------- result checking

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on result %0d, %s: expected %0d, got %0d",
					results_seen, name, want, got);
		end
	endtask

	task automatic take_status();
		health_status_t want;
		if (due_status.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result %0d arrived with no tick item outstanding", results_seen);
		end else begin
			want = due_status.pop_front();
			check_field("probe_level_0", want.lvl[0], status_ch.probe_level_0);
			check_field("probe_level_1", want.lvl[1], status_ch.probe_level_1);
			check_field("probe_level_2", want.lvl[2], status_ch.probe_level_2);
			check_field("probe_level_3", want.lvl[3], status_ch.probe_level_3);
			check_field("heap_lvl", want.heap, status_ch.heap_lvl);
			check_field("heap_ratio_permille", want.ratio, status_ch.heap_ratio_permille);
			check_field("transition_mask", want.mask, status_ch.transition_mask);
			level_changes += $countones(want.mask);
		end
		results_seen++;
	endtask

	always @(posedge clk) begin
		if (status_ch.valid === 1'b1 && status_ch.ready === 1'b1)
			take_status();
		if (stall_left > 0) begin
			stall_left--;
			status_ch.ready <= 1'b0;
		end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			status_ch.ready <= 1'b0;
		end else begin
			status_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- tests

	// Field extremes, threshold edges, invalid probes, ratio zero and clamp
	task automatic test_directed();
		tick_item_t seq [12];
		seq[0]  = mk_tick(4'h0, 0, 0, 0, 0, 24'd0, 24'd0);
		seq[1]  = mk_tick(4'hF, 0, 512, 513, 1024, 24'hFFFFFF, 24'hFFFFFF);
		seq[2]  = mk_tick(4'hF, 1023, 1024, 1535, 1536, 24'hFFFFFF, 24'd1);
		seq[3]  = mk_tick(4'hF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 24'd1, 24'hFFFFFF);
		seq[4]  = mk_tick(4'h5, 0, 0, 0, 0, 24'd131072, 24'd65536);
		seq[5]  = mk_tick(4'hA, 0, 0, 0, 0, 24'd98305, 24'd49153);
		seq[6]  = mk_tick(4'hF, 1536, 1025, 511, 20'hFFFFF, 24'd65537, 24'd32769);
		seq[7]  = mk_tick(4'hF, 2000, 1024, 1024, 1536, 24'd200000, 24'd70000);
		seq[8]  = mk_tick(4'hF, 600, 20'hFFFFF, 0, 1000, 24'd200000, 24'd50001);
		seq[9]  = mk_tick(4'hF, 513, 1535, 20'hFFFFF, 512, 24'd200000, 24'd90000);
		seq[10] = mk_tick(4'hF, 20'hFFFFF, 0, 1536, 1025, 24'hFFFFFF, 24'hFFFFFF);
		seq[11] = mk_tick(4'h0, 0, 0, 0, 0, 24'd65536, 24'd65536);
		foreach (seq[i]) begin
			send_tick(seq[i]);
			send_tick(seq[i]);
		end
		drain();
	endtask

	task automatic test_default_random();
		run_ticks(280);
		drain();
	endtask

	task automatic test_random_config();
		thresholds_t c;
		for (int p = 0; p < 4; p++) begin
			c.warn_on = HR_W'($urandom_range(0, 4096));
			c.warn_off = HR_W'($urandom_range(0, 4096));
			c.crit_on = HR_W'($urandom_range(0, 4096));
			c.crit_off = HR_W'($urandom_range(0, 4096));
			c.fr_warn = HEAP_W'($urandom_range(0, 300000));
			c.fr_crit = HEAP_W'($urandom_range(0, 300000));
			c.fr_ok = HEAP_W'($urandom_range(0, 300000));
			c.confirm = CNT_W'($urandom_range(1, 4));
			program_limits(c);
			run_ticks(50);
			drain();
		end
	endtask

	// All-zero thresholds with immediate adoption, then all-ones, and a write
	// to an index past the register list
	task automatic test_extreme_config();
		thresholds_t c;
		c = '0;
		program_limits(c);
		run_ticks(80);
		drain();
		c = '1;
		c.confirm = 8'd1;
		program_limits(c);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		wr_en <= 1'b0;
		@(posedge clk);
		run_ticks(80);
		drain();
	endtask

	// Longest confirmation run: the change must land on the 255th agreeing sample
	task automatic test_slow_confirm();
		thresholds_t c;
		tick_item_t calm;
		c = RESET_LIMITS;
		c.confirm = COUNT_MAX;
		program_limits(c);
		calm = mk_tick(4'hF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
			24'hFFFFFF, 24'hFFFFFF);
		for (int k = 0; k < 260; k++) begin
			steady_flow = (k % 64) < 16;
			send_tick(calm);
		end
		steady_flow = 1'b0;
		run_ticks(20);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.probe_valid_0 = 1'b0;
		tick_ch.probe_valid_1 = 1'b0;
		tick_ch.probe_valid_2 = 1'b0;
		tick_ch.probe_valid_3 = 1'b0;
		tick_ch.probe_headroom_0 = '0;
		tick_ch.probe_headroom_1 = '0;
		tick_ch.probe_headroom_2 = '0;
		tick_ch.probe_headroom_3 = '0;
		tick_ch.heap_free_bytes = '0;
		tick_ch.heap_largest_block = '0;
		status_ch.ready = 1'b0;
		stall_left = 0;
		steady_flow = 1'b0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		level_changes = 0;
		settings_used = 1;
		thr = RESET_LIMITS;
		for (int ch = 0; ch < 5; ch++) begin
			chan_lvl[ch] = LVL_OK;
			chan_pend[ch] = LVL_OK;
			chan_cnt[ch] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_default_random();
		test_random_config();
		test_extreme_config();
		test_slow_confirm();

		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d tick items under %0d threshold settings, %0d results checked.",
			items_sent, settings_used, results_seen);
		$display("Level changes expected: %0d, mismatches: %0d.", level_changes, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
